// ===== src/text_window_char_writer_macros.svh =====
// assertion macros for the text window writer
`ifndef TEXT_WINDOW_CHAR_WRITER_MACROS_SVH
`define TEXT_WINDOW_CHAR_WRITER_MACROS_SVH
// implication checked on every clock edge outside reset
`define TWCW_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define TWCW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/twcw_pkg.sv =====
// package: types, constants and codes of the text window writer
package twcw_pkg;
  localparam int unsigned MaxRows = 25;
  localparam int unsigned MaxCols = 80;
  localparam int unsigned Depth = MaxRows * MaxCols;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned RowW = 5;
  localparam int unsigned ColW = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 7;
  localparam logic [7:0] SpaceCode = 8'h20;
  localparam logic [7:0] NlCode = 8'h0a;
  localparam logic [7:0] CrCode = 8'h0d;
  localparam logic [7:0] BsCode = 8'h08;

  typedef enum logic [2:0] {
    KindPut = 3'd0, KindMove = 3'd1, KindErase = 3'd2,
    KindEol = 3'd3, KindBottom = 3'd4, KindRead = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    CfgTop = 3'd0, CfgLeft = 3'd1, CfgRows = 3'd2, CfgCols = 3'd3,
    CfgScroll = 3'd4, CfgScrRows = 3'd5, CfgScrCols = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] char_code;
    logic [4:0] cell_row;
    logic [6:0] cell_col;
  } in_beat_t;

  typedef struct packed {
    logic       status;
    logic [7:0] read_char;
    logic [4:0] cursor_row_out;
    logic [6:0] cursor_col_out;
  } out_beat_t;

  typedef enum logic [3:0] {
    StClear, StIdle, StDecode, StRead, StFill, StScrRd, StScrWr, StScrLast, StDone
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_item;   // capture input beat
    logic clr_init;    // reset clearing sweep step
    logic do_decode;   // simple commands, set up regions
    logic rd_cell;     // read issued last cycle, capture
    logic fill_step;   // write a space, advance region
    logic scr_rd;      // issue scroll source read
    logic scr_wr;      // write scroll dest, advance
    logic scr_last;    // set up last row fill
    logic out_load;    // present result
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic need_read;
    logic need_fill;
    logic need_scroll;
    logic region_last;
  } sts_t;
endpackage

// ===== src/twcw_ram.sv =====
// generic single-port ram with registered read
module twcw_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/twcw_ctrl.sv =====
// controller state machine of the text window writer
module twcw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  twcw_pkg::sts_t    sts_i,
  output twcw_pkg::ctl_t    ctl_o
);
  import twcw_pkg::*;
  `include "text_window_char_writer_macros.svh"

  state_e state_q, state_d;
  logic   ovalid_q, ovalid_d;
  logic   free;

  assign free = !ovalid_q || !out_stall_i;
  assign out_valid_o = ovalid_q;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:   if (sts_i.clr_done) state_d = StIdle;
      StIdle:    if (in_valid_i) state_d = StDecode;
      StDecode: begin
        if (sts_i.need_read) state_d = StRead;
        else if (sts_i.need_fill) state_d = StFill;
        else if (sts_i.need_scroll) state_d = StScrRd;
        else state_d = StDone;
      end
      StRead:    state_d = StDone;
      StFill:    if (sts_i.region_last) state_d = StDone;
      StScrRd:   state_d = StScrWr;
      StScrWr:   state_d = sts_i.region_last ? StScrLast : StScrRd;
      StScrLast: state_d = StFill;
      StDone:    if (free) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    ctl_o = '0;
    ctl_o.load_item = (state_q == StIdle) && in_valid_i;
    case (state_q)
      StClear:   ctl_o.clr_init = 1'b1;
      StDecode:  ctl_o.do_decode = 1'b1;
      StRead:    ctl_o.rd_cell = 1'b1;
      StFill:    ctl_o.fill_step = 1'b1;
      StScrRd:   ctl_o.scr_rd = 1'b1;
      StScrWr:   ctl_o.scr_wr = 1'b1;
      StScrLast: ctl_o.scr_last = 1'b1;
      StDone:    ctl_o.out_load = free;
      default:   ;
    endcase
  end

  always_comb begin
    ovalid_d = ovalid_q;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    if (ctl_o.out_load) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  `TWCW_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != StIdle, in_stall_o)
  `TWCW_ASSERT_NEXT(a_accept_decode, clk_i, rst_ni, ctl_o.load_item, state_q == StDecode)
  `TWCW_ASSERT_NEXT(a_out_load_valid, clk_i, rst_ni, ctl_o.out_load, out_valid_o)
endmodule

// ===== src/twcw_dp.sv =====
// datapath: cursor, window registers, region walker and screen memory
module twcw_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [twcw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [twcw_pkg::CfgDataW-1:0] cfg_data_i,
  input  twcw_pkg::in_beat_t           in_data_i,
  output twcw_pkg::out_beat_t          out_data_o,
  input  twcw_pkg::ctl_t               ctl_i,
  output twcw_pkg::sts_t               sts_o
);
  import twcw_pkg::*;

  logic [4:0] wtop_q, wrows_q, srows_q;
  logic [6:0] wleft_q, wcols_q, scols_q;
  logic       scroll_q;
  logic [4:0] crow_q, crow_d;
  logic [6:0] ccol_q, ccol_d;
  in_beat_t   item_q;
  out_beat_t  out_q;
  logic       status_q, status_d;
  logic [7:0] rchar_q;

  // region walker: screen rows r0..r1-1, cols c0..c1-1 (screen coords)
  logic [6:0] rr_q, rr_d, r1_q, r1_d;
  logic [7:0] cc_q, cc_d, c0_q, c0_d, c1_q, c1_d;
  logic       nfill_d, nscr_d, nread_d;
  logic [AddrW-1:0] clr_q;

  logic [4:0] sh;
  logic [6:0] sw;
  assign sh = (srows_q < 5'(MaxRows)) ? srows_q : 5'(MaxRows);
  assign sw = (scols_q < 7'(MaxCols)) ? scols_q : 7'(MaxCols);

  // memory port
  logic             we;
  logic [AddrW-1:0] addr;
  logic [7:0]       wdata, rdata;
  logic [6:0]       arow;
  logic [7:0]       acol;
  logic             on_scr;
  logic [7:0]       ram_wdata;
  logic             ram_we;

  twcw_ram #(.Width(8), .Depth(Depth)) u_ram (
    .clk_i, .we_i(ram_we), .addr_i(addr), .wdata_i(ram_wdata), .rdata_o(rdata)
  );

  // cell put/read addressing
  logic [5:0] gy;
  logic [7:0] gx;
  logic [4:0] cy;
  logic [6:0] cx;
  logic       cell_ok;
  logic [7:0] ch;
  logic       is_bs;
  logic [6:0] bs_col;

  assign ch = item_q.char_code;
  assign bs_col = (ccol_q != '0) ? ccol_q - 7'd1 : ccol_q;
  always_comb begin
    if (item_q.kind == KindRead) begin
      cy = item_q.cell_row;
      cx = item_q.cell_col;
    end else begin
      cy = crow_q;
      cx = (ch == BsCode) ? bs_col : ccol_q;
    end
  end
  assign gy = 6'(wtop_q) + 6'(cy);
  assign gx = 8'(wleft_q) + 8'(cx);
  assign cell_ok = (cy < wrows_q) && (cx < wcols_q) && (gy < 6'(sh)) && (gx < 8'(sw));
  assign is_bs = ch == BsCode;

  // scroll / row advance decision
  logic [6:0] col_inc;
  logic       adv;
  logic [4:0] adv_row;
  logic       do_scroll;
  assign col_inc = ccol_q + 7'd1;
  always_comb begin
    adv = 1'b0;
    if (item_q.kind == KindPut) begin
      if (ch == NlCode) adv = 1'b1;
      else if (!is_bs && ch != CrCode && cell_ok && col_inc >= wcols_q) adv = 1'b1;
    end
    adv_row = (crow_q < wrows_q) ? crow_q + 5'd1 : crow_q;
    do_scroll = adv && adv_row >= wrows_q && scroll_q && wrows_q != '0 && wcols_q != '0;
  end

  logic [7:0] eol_c0;
  logic [6:0] wtop7;
  assign eol_c0 = 8'(wleft_q) + 8'(ccol_q);
  assign wtop7 = 7'(wtop_q);

  // decode, fill and scroll steps: cursor, status, region walker and memory port
  always_comb begin
    crow_d = crow_q;
    ccol_d = ccol_q;
    status_d = status_q;
    rr_d = rr_q; r1_d = r1_q; cc_d = cc_q; c0_d = c0_q; c1_d = c1_q;
    nfill_d = 1'b0; nscr_d = 1'b0; nread_d = 1'b0;
    we = 1'b0;
    arow = rr_q;
    acol = cc_q;
    wdata = SpaceCode;
    if (ctl_i.do_decode) begin
      status_d = 1'b0;
      arow = 7'(gy);
      acol = gx;
      c0_d = 8'(wleft_q);
      c1_d = 8'(wleft_q) + 8'(wcols_q);
      cc_d = 8'(wleft_q);
      case (item_q.kind)
        KindPut: begin
          if (ch == NlCode) begin
            ccol_d = '0;
            crow_d = adv_row;
          end else if (ch == CrCode) begin
            ccol_d = '0;
          end else if (is_bs) begin
            ccol_d = bs_col;
            we = cell_ok;
          end else if (!cell_ok) begin
            status_d = 1'b1;
          end else begin
            we = 1'b1;
            wdata = ch;
            ccol_d = col_inc;
            if (col_inc >= wcols_q) begin
              ccol_d = '0;
              crow_d = adv_row;
            end
          end
          if (do_scroll) begin
            nscr_d = wrows_q > 5'd1;
            nfill_d = wrows_q <= 5'd1;
            rr_d = wtop7;
            r1_d = wtop7 + 7'(wrows_q) - 7'd1;
            crow_d = wrows_q - 5'd1;
            ccol_d = '0;
            if (wrows_q <= 5'd1) begin
              r1_d = wtop7 + 7'd1;
            end
          end
        end
        KindMove: begin
          if (item_q.cell_row < wrows_q && item_q.cell_col < wcols_q) begin
            crow_d = item_q.cell_row;
            ccol_d = item_q.cell_col;
          end else begin
            status_d = 1'b1;
          end
        end
        KindErase: begin
          rr_d = wtop7;
          r1_d = wtop7 + 7'(wrows_q);
          nfill_d = 1'b1;
          crow_d = '0;
          ccol_d = '0;
        end
        KindEol, KindBottom: begin
          rr_d = wtop7 + 7'(crow_q);
          r1_d = rr_d + 7'd1;
          if (item_q.kind == KindBottom && crow_q < wrows_q) r1_d = wtop7 + 7'(wrows_q);
          cc_d = eol_c0;
          nfill_d = 1'b1;
          if (ccol_q >= wcols_q) begin
            if (item_q.kind == KindBottom && 6'(crow_q) + 6'd1 < 6'(wrows_q)) begin
              rr_d = wtop7 + 7'(crow_q) + 7'd1;
              cc_d = 8'(wleft_q);
            end else begin
              nfill_d = 1'b0;
            end
          end
        end
        KindRead: begin
          nread_d = cell_ok;
          status_d = !cell_ok;
        end
        default: status_d = 1'b1;
      endcase
      if (r1_d == rr_d) nfill_d = 1'b0;
      if (c1_d == c0_d) nfill_d = 1'b0;
    end else if (ctl_i.fill_step) begin
      we = on_scr;
      if (cc_q + 8'd1 >= c1_q) begin
        cc_d = c0_q;
        rr_d = rr_q + 7'd1;
      end else begin
        cc_d = cc_q + 8'd1;
      end
    end else if (ctl_i.scr_rd) begin
      arow = rr_q + 7'd1;
    end else if (ctl_i.scr_wr) begin
      we = on_scr;
      wdata = (rr_q + 7'd1 < 7'(sh) && cc_q < 8'(sw)) ? rdata : SpaceCode;
      if (cc_q + 8'd1 >= c1_q) begin
        cc_d = c0_q;
        rr_d = rr_q + 7'd1;
      end else begin
        cc_d = cc_q + 8'd1;
      end
    end else if (ctl_i.scr_last) begin
      r1_d = rr_q + 7'd1;
      cc_d = c0_q;
    end
  end

  logic [AddrW-1:0] lin;
  assign on_scr = (arow < 7'(sh)) && (acol < 8'(sw));
  assign lin = AddrW'(arow) * AddrW'(MaxCols) + AddrW'(acol);
  assign addr = ctl_i.clr_init ? clr_q : lin;

  logic region_last;
  assign region_last = (cc_q + 8'd1 >= c1_q) && (rr_q + 7'd1 >= r1_q);

  assign sts_o.clr_done = clr_q == AddrW'(Depth - 1);
  assign sts_o.need_read = nread_d;
  assign sts_o.need_fill = nfill_d;
  assign sts_o.need_scroll = nscr_d;
  assign sts_o.region_last = region_last;

  assign ram_we = ctl_i.clr_init ? 1'b1 : we;
  assign ram_wdata = ctl_i.clr_init ? SpaceCode : wdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wtop_q <= '0; wleft_q <= '0; wrows_q <= 5'd25; wcols_q <= 7'd80;
      scroll_q <= 1'b0; srows_q <= 5'd25; scols_q <= 7'd80;
      crow_q <= '0; ccol_q <= '0;
      clr_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgTop:     wtop_q <= cfg_data_i[4:0];
          CfgLeft:    wleft_q <= cfg_data_i;
          CfgRows:    wrows_q <= cfg_data_i[4:0];
          CfgCols:    wcols_q <= cfg_data_i;
          CfgScroll:  scroll_q <= cfg_data_i[0];
          CfgScrRows: srows_q <= cfg_data_i[4:0];
          CfgScrCols: scols_q <= cfg_data_i;
          default:    ;
        endcase
      end
      if (ctl_i.clr_init) clr_q <= clr_q + AddrW'(1);
      crow_q <= crow_d;
      ccol_q <= ccol_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) item_q <= in_data_i;
    status_q <= status_d;
    rr_q <= rr_d; r1_q <= r1_d; cc_q <= cc_d; c0_q <= c0_d; c1_q <= c1_d;
    if (ctl_i.do_decode) rchar_q <= '0;
    if (ctl_i.rd_cell) rchar_q <= rdata;
    if (ctl_i.out_load) begin
      out_q.status <= status_q;
      out_q.read_char <= rchar_q;
      out_q.cursor_row_out <= crow_q;
      out_q.cursor_col_out <= ccol_q;
    end
  end
  assign out_data_o = out_q;
endmodule

// ===== src/text_window_char_writer.sv =====
// top level of the text window writer
// Each beat passes through capture, one screen-memory access and result; a
// cell read adds a capture step. Erase and clears step through every cell
// of the region they cover, counted before clipping to the screen. A scroll
// reads and then writes each cell of every window row but the last, passes a
// setup step, and then fills each cell of the last row with spaces.
// After reset a clearing pass writes spaces over all 2000 cells of the screen
// memory; no beat is accepted meanwhile.
module text_window_char_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  twcw_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output twcw_pkg::out_beat_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [twcw_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [twcw_pkg::CfgDataW-1:0] cfg_data_i
);
  import twcw_pkg::*;
  ctl_t ctl;
  sts_t sts;

  twcw_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i(sts), .ctl_o(ctl)
  );
  twcw_dp u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_data_i, .out_data_o,
    .ctl_i(ctl), .sts_o(sts)
  );
endmodule
